// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset
`define ASSERT_NEVER_AT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER_AT(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/dfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfsd_pkg
// Types and constants shared by the delta frame segment decoder modules.
// ----------------------------------------------------------------------------
package dfsd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgOnColor   = 2'd0;
  localparam logic [1:0] CfgOffColor  = 2'd1;
  localparam logic [1:0] CfgMaxSegLen = 2'd2;

  // Configuration reset values
  localparam logic [15:0] OnColorRst   = 16'hFFFF;
  localparam logic [15:0] OffColorRst  = 16'h0000;
  localparam logic [8:0]  MaxSegLenRst = 9'd240;

  // Result kinds
  localparam logic KindPixel = 1'b0;
  localparam logic KindAbort = 1'b1;

  // Bytes of a segment header, charged against the frame budget
  localparam logic [18:0] SegHdrBytes = 19'd3;

  // One job per pixel byte (up to eight results) or one abort result
  typedef struct packed {
    logic       kind;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] bits;     // MSB is the next pixel
    logic [3:0] cnt;      // results still to emit, 1..8
    logic       seg_end;  // final pixel of the job closes the segment
  } job_t;

endpackage

// ===== rtl/dfsd_parser.sv =====
// ----------------------------------------------------------------------------
// dfsd_parser
// Stream parser: frame header, segment headers, budget and bounds checks.
// Turns each pixel byte or bounds failure into one job for the serializer.
// ----------------------------------------------------------------------------
module dfsd_parser
  import dfsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  input  logic [8:0] max_seg_len_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhHeader = 5'b00010,
    PhSegHdr = 5'b00100,
    PhPixels = 5'b01000,
    PhDrop   = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  fbi_q, fbi_d;
  logic [7:0]  hdr_low_q, hdr_low_d;
  logic [15:0] packed_q, packed_d;
  logic [18:0] budget_q, budget_d;
  logic [15:0] segs_q, segs_d;
  logic [7:0]  row_q, row_d;
  logic [7:0]  col_q, col_d;
  logic [8:0]  pix_left_q, pix_left_d;
  logic [8:0]  pix_idx_q, pix_idx_d;

  // Datapath helpers
  logic [15:0] segs_new;
  logic [18:0] budget_hdr;
  logic [8:0]  seg_len;
  logic [9:0]  len_round;
  logic [6:0]  packs;
  logic [3:0]  take;
  logic [15:0] segs_dec;

  assign segs_new   = {data_byte_i, hdr_low_q};
  assign budget_hdr = {3'b000, packed_q} + {3'b000, segs_new} + {2'b00, segs_new, 1'b0};
  assign seg_len    = {1'b0, data_byte_i} - {1'b0, col_q} + 9'd1;
  assign len_round  = {1'b0, seg_len} + 10'd7;
  assign packs      = len_round[9:3];
  assign take       = (pix_left_q >= 9'd8) ? 4'd8 : pix_left_q[3:0];
  assign segs_dec   = segs_q - 16'd1;

  // Next state and job
  always_comb begin
    phase_d    = phase_q;
    fbi_d      = fbi_q;
    hdr_low_d  = hdr_low_q;
    packed_d   = packed_q;
    budget_d   = budget_q;
    segs_d     = segs_q;
    row_d      = row_q;
    col_d      = col_q;
    pix_left_d = pix_left_q;
    pix_idx_d  = pix_idx_q;

    job_valid_o    = 1'b0;
    job_o.kind     = KindAbort;
    job_o.row      = 8'd0;
    job_o.col      = 8'd0;
    job_o.bits     = 8'd0;
    job_o.cnt      = 4'd1;
    job_o.seg_end  = 1'b0;

    if (fire_i) begin
      if (frame_start_i) begin
        phase_d   = PhHeader;
        hdr_low_d = data_byte_i;
        fbi_d     = 2'd1;
      end else begin
        case (phase_q)
          PhHeader: begin
            case (fbi_q)
              2'd1: begin
                packed_d = {data_byte_i, hdr_low_q};
                fbi_d    = 2'd2;
              end
              2'd3: begin
                segs_d   = segs_new;
                budget_d = budget_hdr;
                fbi_d    = 2'd0;
                phase_d  = (segs_new == 16'd0) ? PhIdle : PhSegHdr;
              end
              default: begin
                hdr_low_d = data_byte_i;
                fbi_d     = fbi_q + 2'd1;
              end
            endcase
          end
          PhSegHdr: begin
            case (fbi_q)
              2'd0: begin
                if (budget_q < SegHdrBytes) begin
                  job_valid_o = 1'b1;
                  phase_d     = PhDrop;
                end else begin
                  budget_d = budget_q - SegHdrBytes;
                  row_d    = data_byte_i;
                  fbi_d    = 2'd1;
                end
              end
              2'd1: begin
                col_d = data_byte_i;
                fbi_d = 2'd2;
              end
              default: begin
                // end column: order, length and budget checks
                if ((data_byte_i < col_q) || (seg_len > max_seg_len_i) ||
                    ({12'd0, packs} > budget_q)) begin
                  job_valid_o = 1'b1;
                  phase_d     = PhDrop;
                end else begin
                  budget_d   = budget_q - {12'd0, packs};
                  pix_left_d = seg_len;
                  pix_idx_d  = 9'd0;
                  fbi_d      = 2'd0;
                  phase_d    = PhPixels;
                end
              end
            endcase
          end
          PhPixels: begin
            job_valid_o   = 1'b1;
            job_o.kind    = KindPixel;
            job_o.row     = row_q;
            job_o.col     = col_q + pix_idx_q[7:0];
            job_o.bits    = data_byte_i;
            job_o.cnt     = take;
            job_o.seg_end = (pix_left_q <= 9'd8);
            pix_left_d    = pix_left_q - {5'd0, take};
            pix_idx_d     = pix_idx_q + {5'd0, take};
            if (pix_left_q <= 9'd8) begin
              segs_d  = segs_dec;
              fbi_d   = 2'd0;
              phase_d = (segs_dec == 16'd0) ? PhIdle : PhSegHdr;
            end
          end
          default: ;  // idle or dropping: byte ignored
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      fbi_q      <= 2'd0;
      hdr_low_q  <= 8'd0;
      packed_q   <= 16'd0;
      budget_q   <= 19'd0;
      segs_q     <= 16'd0;
      row_q      <= 8'd0;
      col_q      <= 8'd0;
      pix_left_q <= 9'd0;
      pix_idx_q  <= 9'd0;
    end else begin
      phase_q    <= phase_d;
      fbi_q      <= fbi_d;
      hdr_low_q  <= hdr_low_d;
      packed_q   <= packed_d;
      budget_q   <= budget_d;
      segs_q     <= segs_d;
      row_q      <= row_d;
      col_q      <= col_d;
      pix_left_q <= pix_left_d;
      pix_idx_q  <= pix_idx_d;
    end
  end

endmodule

// ===== rtl/dfsd_serializer.sv =====
// ----------------------------------------------------------------------------
// dfsd_serializer
// Result register: holds one job and emits its results one beat per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module dfsd_serializer
  import dfsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_ready_o,
  input  logic [15:0] on_color_i,
  input  logic [15:0] off_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  row_o,
  output logic [7:0]  column_o,
  output logic [15:0] color_o,
  output logic        segment_end_o,
  output logic        last_o
);

  logic valid_q, valid_d;
  job_t job_q, job_d;
  logic is_last;

  assign is_last     = (job_q.cnt == 4'd1);
  assign job_ready_o = !valid_q || (out_ready_i && is_last);

  // Advance within a job or load the next one
  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    if (job_ready_o) begin
      valid_d = job_valid_i;
      job_d   = job_i;
    end else if (out_ready_i) begin
      job_d.bits = {job_q.bits[6:0], 1'b0};
      job_d.col  = job_q.col + 8'd1;
      job_d.cnt  = job_q.cnt - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  // Result fields
  assign out_valid_o   = valid_q;
  assign kind_o        = job_q.kind;
  assign row_o         = job_q.row;
  assign column_o      = job_q.col;
  assign color_o       = (job_q.kind == KindAbort) ? 16'd0 :
                         (job_q.bits[7] ? on_color_i : off_color_i);
  assign segment_end_o = job_q.seg_end && is_last;
  assign last_o        = is_last;

endmodule

// ===== rtl/delta_frame_segment_decoder.sv =====
// ----------------------------------------------------------------------------
// delta_frame_segment_decoder
// Decodes a byte stream of delta video frames into per-pixel results.
// ----------------------------------------------------------------------------
// Bytes are accepted while the output serializer can take a new job. Header
// and ignored bytes leave no result, nor do segment header bytes that pass
// their checks; a pixel byte yields one result per covered pixel (up to
// eight) and the output serializer emits one result per cycle while
// out_ready_i is high. A bounds failure emits one abort result and drops the
// rest of the frame until the next frame start. The next byte is taken in
// the cycle the last result of the previous byte is taken.
module delta_frame_segment_decoder
  import dfsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  row_o,
  output logic [7:0]  column_o,
  output logic [15:0] color_o,
  output logic        segment_end_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

`include "assert_macros.svh"

  logic [15:0] on_color_q;
  logic [15:0] off_color_q;
  logic [8:0]  max_seg_len_q;
  logic        in_fire;
  logic        job_valid;
  logic        job_ready;
  job_t        job;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_color_q    <= OnColorRst;
      off_color_q   <= OffColorRst;
      max_seg_len_q <= MaxSegLenRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgOnColor:   on_color_q    <= cfg_wdata_i;
        CfgOffColor:  off_color_q   <= cfg_wdata_i;
        CfgMaxSegLen: max_seg_len_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = job_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  dfsd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .max_seg_len_i (max_seg_len_q),
    .job_valid_o   (job_valid),
    .job_o         (job)
  );

  dfsd_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_ready_o   (job_ready),
    .on_color_i    (on_color_q),
    .off_color_i   (off_color_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .row_o         (row_o),
    .column_o      (column_o),
    .color_o       (color_o),
    .segment_end_o (segment_end_o),
    .last_o        (last_o)
  );

  // Checks
  `ASSERT_AT(a_abort_shape, clk_i, rst_ni,
    (out_valid_o && kind_o == KindAbort) |-> (last_o && !segment_end_o && color_o == 16'd0))
  `ASSERT_AT(a_seg_end_last, clk_i, rst_ni, (out_valid_o && segment_end_o) |-> last_o)
  `ASSERT_NEVER_AT(a_no_take_mid_byte, clk_i, rst_ni, in_ready_o && out_valid_o && !last_o)
  `ASSERT_AT(a_column_step, clk_i, rst_ni,
    (out_valid_o && out_ready_i && !last_o) |=>
      (out_valid_o && column_o == 8'($past(column_o) + 8'd1)))

endmodule
